### src/ttco_pkg.sv
// Package with the request and response types, codes and constants of the triple timer.
package ttco_pkg;

  localparam int CNT_W   = 32;
  localparam int MODE_W  = 12;
  localparam int RATIO_W = 14;
  localparam int IRQ_W   = 3;
  localparam int NUM_W   = 5;
  localparam int OFF_W   = 4;
  localparam int MODE_WR_BITS = 10;

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;

  localparam logic [OFF_W-1:0] OFF_COUNT   = 4'd0;
  localparam logic [OFF_W-1:0] OFF_MODE    = 4'd1;
  localparam logic [OFF_W-1:0] OFF_COMPARE = 4'd2;
  localparam logic [OFF_W-1:0] OFF_HOLD    = 4'd3;

  localparam logic [1:0] CLK_DIV1   = 2'd0;
  localparam logic [1:0] CLK_DIV16  = 2'd1;
  localparam logic [1:0] CLK_DIV256 = 2'd2;
  localparam logic [1:0] CLK_HBLANK = 2'd3;

  localparam int MODE_CLR_ON_CMP = 6;
  localparam int MODE_ENABLE     = 7;
  localparam int MODE_CMP_IE     = 8;
  localparam int MODE_OVF_IE     = 9;
  localparam int MODE_CMP_FLAG   = 10;
  localparam int MODE_OVF_FLAG   = 11;

  localparam logic [CNT_W-1:0] OVF_STEP = 32'h0000_ffff;

  // Remainder unit: four dividend bits per cycle.
  localparam int MOD_STEP_BITS = 4;
  localparam int MOD_DIGITS    = CNT_W / MOD_STEP_BITS;
  localparam int MOD_CNT_W     = $clog2(MOD_DIGITS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_MOD,
    S_STEP,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [9:0]  tick_cycles;
    logic [15:0] bus_address;
    logic [31:0] write_data;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [2:0]  irq_raised;
  } rsp_t;

endpackage

### src/ttco_mod.sv
// Iterative remainder unit that tests a prescale accumulator for an exact multiple of its ratio.
module ttco_mod (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ttco_pkg::CNT_W-1:0]    dividend,
  input  logic [ttco_pkg::RATIO_W-1:0]  divisor,
  output logic                          done,
  output logic                          rem_zero
);

  logic                              running;
  logic [ttco_pkg::MOD_CNT_W-1:0]    digit;
  logic [ttco_pkg::CNT_W-1:0]        dvd;
  logic [ttco_pkg::RATIO_W-1:0]      divr;
  logic [ttco_pkg::RATIO_W-1:0]      rem;
  logic [ttco_pkg::RATIO_W-1:0]      rem_next;
  logic [ttco_pkg::CNT_W-1:0]        dvd_next;

  always_comb begin
    logic [ttco_pkg::RATIO_W:0] wide;
    rem_next = rem;
    dvd_next = dvd;
    for (int i = 0; i < ttco_pkg::MOD_STEP_BITS; i++) begin
      wide = {rem_next, dvd_next[ttco_pkg::CNT_W-1]};
      if (wide >= {1'b0, divr}) begin
        wide = wide - {1'b0, divr};
      end
      rem_next = wide[ttco_pkg::RATIO_W-1:0];
      dvd_next = {dvd_next[ttco_pkg::CNT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      digit   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        digit   <= '0;
      end else if (running) begin
        digit <= digit + 1'b1;
        if (digit == ttco_pkg::MOD_CNT_W'(ttco_pkg::MOD_DIGITS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= dividend;
      divr <= divisor;
      rem  <= '0;
    end else if (running) begin
      dvd      <= dvd_next;
      rem      <= rem_next;
      rem_zero <= (rem_next == '0);
    end
  end

endmodule

### src/triple_timer_compare_overflow.sv
// Top level of the triple timer with prescaler, compare and overflow interrupts.
// A read or write request is accepted when start is high and busy is low; its response
// appears on rsp with done high in the next cycle, and busy stays low, so another request
// can follow at once. A tick request visits the timers one after another through a single
// shared remainder unit: a disabled timer is passed over, an enabled timer whose accumulator
// is not a multiple of its ratio is only checked, and a timer whose accumulator is a multiple
// counts. Busy is high until the last timer is through, and the response strobe follows in
// the next cycle. Responses cannot be held off by the receiver.
module triple_timer_compare_overflow #(
  parameter int NUM_TIMERS   = 3,
  parameter int HBLANK_RATIO = 9371
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  ttco_pkg::req_t  req,
  output logic            done,
  output ttco_pkg::rsp_t  rsp
);

  localparam int TW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  ttco_pkg::state_t state;
  ttco_pkg::state_t state_next;

  logic [ttco_pkg::CNT_W-1:0]   count_word     [NUM_TIMERS];
  logic [ttco_pkg::MODE_W-1:0]  mode_word      [NUM_TIMERS];
  logic [ttco_pkg::CNT_W-1:0]   compare_word   [NUM_TIMERS];
  logic [ttco_pkg::CNT_W-1:0]   hold_word      [NUM_TIMERS];
  logic [ttco_pkg::RATIO_W-1:0] prescale_ratio [NUM_TIMERS];
  logic [ttco_pkg::CNT_W-1:0]   prescale_accum [NUM_TIMERS];

  logic [TW-1:0]                cur;
  logic [9:0]                   cycles;
  logic [ttco_pkg::IRQ_W-1:0]   irq_acc;
  logic [ttco_pkg::IRQ_W-1:0]   irq_acc_next;
  logic [ttco_pkg::CNT_W-1:0]   cnt_inc;
  logic                         cmp_cross;

  logic                         accept;
  logic [ttco_pkg::NUM_W-1:0]   num;
  logic [ttco_pkg::OFF_W-1:0]   off;
  logic                         num_ok;
  logic [TW-1:0]                idx;

  logic [ttco_pkg::CNT_W-1:0]   sel_count;
  logic [ttco_pkg::MODE_W-1:0]  sel_mode;
  logic [ttco_pkg::CNT_W-1:0]   sel_compare;
  logic [ttco_pkg::CNT_W-1:0]   sel_hold;
  logic [ttco_pkg::RATIO_W-1:0] sel_ratio;
  logic [ttco_pkg::CNT_W-1:0]   sel_accum;
  logic [ttco_pkg::CNT_W-1:0]   accum_sum;

  logic                         cur_last;
  logic                         enabled;
  logic                         advance;
  logic                         tick_done;
  logic                         mod_start;
  logic                         mod_done;
  logic                         mod_zero;
  logic [ttco_pkg::CNT_W-1:0]   fin_count;
  logic [ttco_pkg::MODE_W-1:0]  fin_mode;
  logic                         fin_irq;
  logic [ttco_pkg::CNT_W-1:0]   read_word;
  logic [ttco_pkg::RATIO_W-1:0] new_ratio;

  assign accept = start && !busy;
  assign busy   = (state != ttco_pkg::S_IDLE);
  assign num    = req.bus_address[15:11];
  assign off    = req.bus_address[7:4];
  assign num_ok = (num < ttco_pkg::NUM_W'(NUM_TIMERS));
  assign idx    = (state == ttco_pkg::S_IDLE) ? num[TW-1:0] : cur;

  assign sel_count   = count_word[idx];
  assign sel_mode    = mode_word[idx];
  assign sel_compare = compare_word[idx];
  assign sel_hold    = hold_word[idx];
  assign sel_ratio   = prescale_ratio[idx];
  assign sel_accum   = prescale_accum[idx];
  assign accum_sum   = sel_accum + ttco_pkg::CNT_W'(cycles);

  assign cur_last = (cur == TW'(NUM_TIMERS - 1));
  assign enabled  = sel_mode[ttco_pkg::MODE_ENABLE];

  ttco_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (accum_sum),
    .divisor  (sel_ratio),
    .done     (mod_done),
    .rem_zero (mod_zero)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ttco_pkg::S_IDLE: begin
        if (accept && req.req_type == ttco_pkg::REQ_TICK) begin
          state_next = ttco_pkg::S_ACC;
        end
      end
      ttco_pkg::S_ACC: begin
        if (enabled) begin
          state_next = ttco_pkg::S_MOD;
        end else if (cur_last) begin
          state_next = ttco_pkg::S_IDLE;
        end
      end
      ttco_pkg::S_MOD: begin
        if (mod_done) begin
          if (mod_zero) begin
            state_next = ttco_pkg::S_STEP;
          end else if (cur_last) begin
            state_next = ttco_pkg::S_IDLE;
          end else begin
            state_next = ttco_pkg::S_ACC;
          end
        end
      end
      ttco_pkg::S_STEP: begin
        state_next = ttco_pkg::S_FIN;
      end
      ttco_pkg::S_FIN: begin
        state_next = cur_last ? ttco_pkg::S_IDLE : ttco_pkg::S_ACC;
      end
      default: begin
        state_next = ttco_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    mod_start = (state == ttco_pkg::S_ACC) && enabled;
    advance   = ((state == ttco_pkg::S_ACC) && !enabled) ||
                ((state == ttco_pkg::S_MOD) && mod_done && !mod_zero) ||
                (state == ttco_pkg::S_FIN);
    tick_done = advance && cur_last;

    fin_count = cnt_inc;
    fin_mode  = sel_mode;
    fin_irq   = 1'b0;
    if (cmp_cross) begin
      if (fin_mode[ttco_pkg::MODE_CMP_IE] && !fin_mode[ttco_pkg::MODE_CMP_FLAG]) begin
        fin_irq = 1'b1;
        fin_mode[ttco_pkg::MODE_CMP_FLAG] = 1'b1;
      end
      if (fin_mode[ttco_pkg::MODE_CLR_ON_CMP]) begin
        fin_count = '0;
      end
    end
    if (fin_count[ttco_pkg::CNT_W-1:16] != '0) begin
      if (fin_mode[ttco_pkg::MODE_OVF_IE] && !fin_mode[ttco_pkg::MODE_OVF_FLAG]) begin
        fin_irq = 1'b1;
        fin_mode[ttco_pkg::MODE_OVF_FLAG] = 1'b1;
      end
      fin_count = fin_count - ttco_pkg::OVF_STEP;
    end

    irq_acc_next = irq_acc;
    if (state == ttco_pkg::S_FIN && fin_irq) begin
      irq_acc_next = irq_acc | (ttco_pkg::IRQ_W'(1) << cur);
    end

    read_word = '0;
    if (num_ok) begin
      unique case (off)
        ttco_pkg::OFF_COUNT:   read_word = sel_count;
        ttco_pkg::OFF_MODE:    read_word = ttco_pkg::CNT_W'(sel_mode);
        ttco_pkg::OFF_COMPARE: read_word = sel_compare;
        ttco_pkg::OFF_HOLD:    read_word = sel_hold;
        default:               read_word = '0;
      endcase
    end

    unique case (req.write_data[1:0])
      ttco_pkg::CLK_DIV1:   new_ratio = ttco_pkg::RATIO_W'(1);
      ttco_pkg::CLK_DIV16:  new_ratio = ttco_pkg::RATIO_W'(16);
      ttco_pkg::CLK_DIV256: new_ratio = ttco_pkg::RATIO_W'(256);
      ttco_pkg::CLK_HBLANK: new_ratio = ttco_pkg::RATIO_W'(HBLANK_RATIO);
      default:              new_ratio = ttco_pkg::RATIO_W'(1);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ttco_pkg::S_IDLE;
      cur     <= '0;
      irq_acc <= '0;
      done    <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (state == ttco_pkg::S_IDLE) begin
        cur     <= '0;
        irq_acc <= '0;
        if (accept && req.req_type != ttco_pkg::REQ_TICK) begin
          done <= 1'b1;
        end
      end else begin
        irq_acc <= irq_acc_next;
        if (advance) begin
          cur <= cur + 1'b1;
        end
        if (tick_done) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ttco_pkg::S_IDLE && accept) begin
      cycles <= req.tick_cycles;
      rsp.irq_raised <= '0;
      rsp.read_data  <= (req.req_type == ttco_pkg::REQ_READ) ? read_word : '0;
    end else if (tick_done) begin
      rsp.irq_raised <= irq_acc_next;
      rsp.read_data  <= '0;
    end
    if (state == ttco_pkg::S_STEP) begin
      cnt_inc   <= sel_count + 1'b1;
      cmp_cross <= (sel_count + 1'b1 == sel_compare) && (sel_count != '1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < NUM_TIMERS; t++) begin
        count_word[t]     <= '0;
        mode_word[t]      <= '0;
        compare_word[t]   <= '0;
        hold_word[t]      <= '0;
        prescale_ratio[t] <= ttco_pkg::RATIO_W'(1);
        prescale_accum[t] <= '0;
      end
    end else begin
      for (int t = 0; t < NUM_TIMERS; t++) begin
        if (idx == TW'(t)) begin
          if (state == ttco_pkg::S_IDLE && accept && num_ok &&
              req.req_type == ttco_pkg::REQ_WRITE) begin
            unique case (off)
              ttco_pkg::OFF_COUNT: begin
                count_word[t] <= req.write_data;
              end
              ttco_pkg::OFF_MODE: begin
                mode_word[t] <=
                  ttco_pkg::MODE_W'(req.write_data[ttco_pkg::MODE_WR_BITS-1:0]);
                prescale_ratio[t] <= new_ratio;
              end
              ttco_pkg::OFF_COMPARE: begin
                compare_word[t] <= req.write_data;
              end
              ttco_pkg::OFF_HOLD: begin
                hold_word[t] <= req.write_data;
              end
              default: begin
              end
            endcase
          end
          if (state == ttco_pkg::S_ACC) begin
            prescale_accum[t] <= accum_sum;
          end
          if (state == ttco_pkg::S_FIN) begin
            count_word[t]     <= fin_count;
            mode_word[t]      <= fin_mode;
            prescale_accum[t] <= '0;
          end
        end
      end
    end
  end

  a_rw_response: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req.req_type != ttco_pkg::REQ_TICK) |=> done)
    else $error("read or write request did not respond in the next cycle");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("response strobe while the sequencer is still busy");

  a_irq_after_tick: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.irq_raised != '0) |-> $past(busy))
    else $error("interrupt reported on a response that did not follow a tick");

  a_mod_wait: assert property (@(posedge clk) disable iff (rst)
    (state == ttco_pkg::S_ACC && enabled) |=> state == ttco_pkg::S_MOD)
    else $error("enabled timer skipped the remainder check");

endmodule

### tb/testbench.sv
// Self-checking testbench for the triple timer: queued bus requests checked against an in-line timer model.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_TIMERS     = 3;
  localparam int HBLANK       = 9371;
  localparam int RANDOM_ITEMS = 1600;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 12 * N_TIMERS + 8;
  localparam int GAP_PCT      = 14;
  localparam int CALM_FROM    = 700;
  localparam int CALM_TO      = 1000;
  localparam int MIX_ITEMS    = 30;

  localparam logic [1:0]                 REQ_UNUSED       = 2'd3;
  localparam logic [ttco_pkg::OFF_W-1:0] OFF_FIRST_UNUSED = 4'd4;
  localparam logic [ttco_pkg::OFF_W-1:0] OFF_LAST         = 4'd15;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  ttco_pkg::req_t req = '0;
  ttco_pkg::rsp_t rsp;

  // Timer state as the bus sees it, advanced once per accepted request.
  logic [ttco_pkg::CNT_W-1:0]   timer_count   [N_TIMERS];
  logic [ttco_pkg::MODE_W-1:0]  timer_mode    [N_TIMERS];
  logic [ttco_pkg::CNT_W-1:0]   timer_compare [N_TIMERS];
  logic [ttco_pkg::CNT_W-1:0]   timer_hold    [N_TIMERS];
  logic [ttco_pkg::RATIO_W-1:0] timer_ratio   [N_TIMERS];
  logic [ttco_pkg::CNT_W-1:0]   timer_accum   [N_TIMERS];

  ttco_pkg::req_t request_backlog[$];
  ttco_pkg::rsp_t owed_responses[$];
  ttco_pkg::rsp_t predicted;
  ttco_pkg::rsp_t oldest;

  int n_accepted = 0;
  int n_fail = 0;
  int n_cycles = 0;
  int n_ticks = 0;
  int n_steps = 0;
  int n_irqs = 0;
  int n_reads = 0;
  int n_writes = 0;
  int n_unused = 0;

  triple_timer_compare_overflow #(
    .NUM_TIMERS  (N_TIMERS),
    .HBLANK_RATIO(HBLANK)
  ) dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .req  (req),
    .done (done),
    .rsp  (rsp)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [ttco_pkg::RATIO_W-1:0] ratio_of(input logic [1:0] sel);
    case (sel)
      ttco_pkg::CLK_DIV1:   return ttco_pkg::RATIO_W'(1);
      ttco_pkg::CLK_DIV16:  return ttco_pkg::RATIO_W'(16);
      ttco_pkg::CLK_DIV256: return ttco_pkg::RATIO_W'(256);
      default:              return ttco_pkg::RATIO_W'(HBLANK);
    endcase
  endfunction

  task automatic run_timer_request(input ttco_pkg::req_t r, output ttco_pkg::rsp_t o);
    logic [ttco_pkg::NUM_W-1:0] num;
    logic [ttco_pkg::OFF_W-1:0] off;
    logic [ttco_pkg::CNT_W-1:0] prev;
    logic [ttco_pkg::CNT_W-1:0] nxt;
    o = '0;
    num = r.bus_address[15:11];
    off = r.bus_address[7:4];
    case (r.req_type)
      ttco_pkg::REQ_TICK: begin
        n_ticks++;
        for (int t = 0; t < N_TIMERS; t++)
          timer_accum[t] += ttco_pkg::CNT_W'(r.tick_cycles);
        for (int t = 0; t < N_TIMERS; t++) begin
          if (timer_mode[t][ttco_pkg::MODE_ENABLE] &&
              ((timer_accum[t] % ttco_pkg::CNT_W'(timer_ratio[t])) == '0)) begin
            prev = timer_count[t];
            nxt = prev + 1;
            if (nxt >= timer_compare[t] && prev < timer_compare[t]) begin
              if (timer_mode[t][ttco_pkg::MODE_CMP_IE] &&
                  !timer_mode[t][ttco_pkg::MODE_CMP_FLAG]) begin
                o.irq_raised[t] = 1'b1;
                timer_mode[t][ttco_pkg::MODE_CMP_FLAG] = 1'b1;
              end
              if (timer_mode[t][ttco_pkg::MODE_CLR_ON_CMP]) nxt = '0;
            end
            if (nxt > ttco_pkg::OVF_STEP) begin
              if (timer_mode[t][ttco_pkg::MODE_OVF_IE] &&
                  !timer_mode[t][ttco_pkg::MODE_OVF_FLAG]) begin
                o.irq_raised[t] = 1'b1;
                timer_mode[t][ttco_pkg::MODE_OVF_FLAG] = 1'b1;
              end
              nxt -= ttco_pkg::OVF_STEP;
            end
            timer_count[t] = nxt;
            timer_accum[t] = '0;
            n_steps++;
          end
        end
        n_irqs += $countones(o.irq_raised);
      end
      ttco_pkg::REQ_READ: begin
        n_reads++;
        if (num < N_TIMERS) begin
          case (off)
            ttco_pkg::OFF_COUNT:   o.read_data = timer_count[num];
            ttco_pkg::OFF_MODE:    o.read_data = ttco_pkg::CNT_W'(timer_mode[num]);
            ttco_pkg::OFF_COMPARE: o.read_data = timer_compare[num];
            ttco_pkg::OFF_HOLD:    o.read_data = timer_hold[num];
            default:               o.read_data = '0;
          endcase
        end
      end
      ttco_pkg::REQ_WRITE: begin
        n_writes++;
        if (num < N_TIMERS) begin
          case (off)
            ttco_pkg::OFF_COUNT:   timer_count[num] = r.write_data;
            ttco_pkg::OFF_MODE: begin
              timer_ratio[num] = ratio_of(r.write_data[1:0]);
              timer_mode[num] =
                ttco_pkg::MODE_W'(r.write_data[ttco_pkg::MODE_WR_BITS-1:0]);
            end
            ttco_pkg::OFF_COMPARE: timer_compare[num] = r.write_data;
            ttco_pkg::OFF_HOLD:    timer_hold[num] = r.write_data;
            default: ;
          endcase
        end
      end
      default: n_unused++;
    endcase
  endtask

  function automatic bit take_gap();
    return (n_accepted < CALM_FROM || n_accepted > CALM_TO) &&
           ($urandom_range(0, 99) < GAP_PCT);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        run_timer_request(req, predicted);
        owed_responses.push_back(predicted);
        n_accepted++;
      end
      if (!(start && busy)) begin
        if (request_backlog.size() > 0 && !take_gap()) begin
          req <= request_backlog.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done !== 1'b0) begin
      if (owed_responses.size() == 0) begin
        $error("response with no request outstanding: read_data %h irq_raised %b",
               rsp.read_data, rsp.irq_raised);
        n_fail++;
      end else begin
        oldest = owed_responses.pop_front();
        if (rsp.read_data !== oldest.read_data) begin
          $error("read_data: expected %h, got %h", oldest.read_data, rsp.read_data);
          n_fail++;
        end
        if (rsp.irq_raised !== oldest.irq_raised) begin
          $error("irq_raised: expected %b, got %b", oldest.irq_raised, rsp.irq_raised);
          n_fail++;
        end
      end
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  task automatic send(input logic [1:0] kind, input logic [9:0] cyc,
                      input logic [15:0] addr, input logic [31:0] data);
    ttco_pkg::req_t r;
    r.req_type = kind;
    r.tick_cycles = cyc;
    r.bus_address = addr;
    r.write_data = data;
    request_backlog.push_back(r);
  endtask

  // Bits that the timer number and offset do not use are filled at random.
  function automatic logic [15:0] addr_of(input int num,
                                          input logic [ttco_pkg::OFF_W-1:0] off);
    return {ttco_pkg::NUM_W'(num), 3'($urandom), off, 4'($urandom)};
  endfunction

  function automatic logic [31:0] mode_data();
    logic [31:0] d;
    d = $urandom;
    d[ttco_pkg::MODE_ENABLE] = ($urandom_range(0, 99) < 85);
    if ($urandom_range(0, 1)) d[1:0] = ttco_pkg::CLK_DIV1;
    return d;
  endfunction

  function automatic logic [1:0] reg_access();
    return $urandom_range(0, 1) ? ttco_pkg::REQ_READ : ttco_pkg::REQ_WRITE;
  endfunction

  task automatic wait_for_quiet();
    while (request_backlog.size() != 0 || start || owed_responses.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    int t;
    int k;
    int sel;
    int gap;
    int n_random;
    logic [31:0] cnt;
    logic [31:0] d;
    logic [9:0] c;
    for (t = 0; t < N_TIMERS; t++) begin
      timer_count[t] = '0;
      timer_mode[t] = '0;
      timer_compare[t] = '0;
      timer_hold[t] = '0;
      timer_ratio[t] = ttco_pkg::RATIO_W'(1);
      timer_accum[t] = '0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send(ttco_pkg::REQ_READ, 10'($urandom), addr_of(0, ttco_pkg::OFF_COUNT), $urandom);
    send(ttco_pkg::REQ_READ, 10'($urandom), addr_of(1, ttco_pkg::OFF_MODE), $urandom);
    send(ttco_pkg::REQ_READ, 10'($urandom), addr_of(2, ttco_pkg::OFF_COMPARE), $urandom);
    // Timer 0 counts every tick with clear on compare; the flag bits of the write are dropped.
    send(ttco_pkg::REQ_WRITE, 10'($urandom), addr_of(0, ttco_pkg::OFF_MODE),
         32'hffff_ffc0 | 32'(ttco_pkg::CLK_DIV1));
    send(ttco_pkg::REQ_WRITE, 10'($urandom), addr_of(0, ttco_pkg::OFF_COMPARE), 32'd2);
    send(ttco_pkg::REQ_WRITE, 10'($urandom), addr_of(0, ttco_pkg::OFF_COUNT), 32'd1);
    d = '0;
    d[ttco_pkg::MODE_ENABLE] = 1'b1;
    d[ttco_pkg::MODE_OVF_IE] = 1'b1;
    d[1:0] = ttco_pkg::CLK_DIV16;
    send(ttco_pkg::REQ_WRITE, 10'($urandom), addr_of(1, ttco_pkg::OFF_MODE), d);
    send(ttco_pkg::REQ_WRITE, 10'($urandom), addr_of(1, ttco_pkg::OFF_COUNT), 32'h0000_ffff);
    d = '0;
    d[ttco_pkg::MODE_ENABLE] = 1'b1;
    d[ttco_pkg::MODE_CMP_IE] = 1'b1;
    d[1:0] = ttco_pkg::CLK_HBLANK;
    send(ttco_pkg::REQ_WRITE, 10'($urandom), addr_of(2, ttco_pkg::OFF_MODE), d);
    send(ttco_pkg::REQ_WRITE, 10'($urandom), addr_of(2, ttco_pkg::OFF_COMPARE),
         32'hffff_ffff);
    send(ttco_pkg::REQ_WRITE, 10'($urandom), addr_of(2, ttco_pkg::OFF_COUNT),
         32'hffff_fffe);
    send(ttco_pkg::REQ_TICK, 10'd0, 16'($urandom), $urandom);
    send(ttco_pkg::REQ_READ, 10'($urandom), addr_of(0, ttco_pkg::OFF_MODE), $urandom);
    // A disabled timer in the middle must not stop the one after it.
    send(ttco_pkg::REQ_WRITE, 10'($urandom), addr_of(1, ttco_pkg::OFF_MODE), 32'd0);
    d = '0;
    d[ttco_pkg::MODE_ENABLE] = 1'b1;
    d[ttco_pkg::MODE_OVF_IE] = 1'b1;
    d[1:0] = ttco_pkg::CLK_DIV1;
    send(ttco_pkg::REQ_WRITE, 10'($urandom), addr_of(2, ttco_pkg::OFF_MODE), d);
    send(ttco_pkg::REQ_TICK, 10'h3ff, 16'($urandom), $urandom);
    send(ttco_pkg::REQ_WRITE, 10'($urandom), addr_of(0, ttco_pkg::OFF_COUNT),
         32'hffff_ffff);
    send(ttco_pkg::REQ_TICK, 10'd1, 16'($urandom), $urandom);
    send(ttco_pkg::REQ_WRITE, 10'($urandom), addr_of(1, ttco_pkg::OFF_HOLD), 32'ha5a5_5a5a);
    send(ttco_pkg::REQ_READ, 10'($urandom), addr_of(1, ttco_pkg::OFF_HOLD), $urandom);
    send(ttco_pkg::REQ_WRITE, 10'($urandom), addr_of(N_TIMERS, ttco_pkg::OFF_COUNT),
         $urandom);
    send(ttco_pkg::REQ_READ, 10'h3ff, 16'hffff, 32'hffff_ffff);
    send(ttco_pkg::REQ_WRITE, 10'($urandom), addr_of(0, OFF_FIRST_UNUSED), $urandom);
    send(ttco_pkg::REQ_READ, 10'($urandom), addr_of(0, OFF_LAST), $urandom);
    send(REQ_UNUSED, 10'h3ff, 16'hffff, 32'hffff_ffff);
    send(ttco_pkg::REQ_READ, 10'($urandom), addr_of(2, ttco_pkg::OFF_COUNT), $urandom);
    send(ttco_pkg::REQ_READ, 10'($urandom), addr_of(0, ttco_pkg::OFF_COUNT), $urandom);

    n_random = 0;
    while (n_random < RANDOM_ITEMS) begin
      wait_for_quiet();
      // Bring one timer's prescaler exactly onto a multiple of its ratio.
      t = $urandom_range(0, N_TIMERS - 1);
      gap = int'((ttco_pkg::CNT_W'(timer_ratio[t]) -
                  timer_accum[t] % ttco_pkg::CNT_W'(timer_ratio[t])) %
                 ttco_pkg::CNT_W'(timer_ratio[t]));
      while (gap > 0) begin
        k = (gap > 1023) ? 1023 : gap;
        send(ttco_pkg::REQ_TICK, 10'(k), 16'($urandom), $urandom);
        gap -= k;
        n_random++;
      end
      for (t = 0; t < N_TIMERS; t++) begin
        if ($urandom_range(0, 1)) begin
          case ($urandom_range(0, 3))
            0:       cnt = $urandom;
            1:       cnt = 32'h0000_ffff - 32'($urandom_range(0, 3));
            2:       cnt = 32'($urandom_range(0, 8));
            default: cnt = 32'hffff_ffff - 32'($urandom_range(0, 3));
          endcase
          send(ttco_pkg::REQ_WRITE, 10'($urandom), addr_of(t, ttco_pkg::OFF_COUNT), cnt);
          send(ttco_pkg::REQ_WRITE, 10'($urandom), addr_of(t, ttco_pkg::OFF_COMPARE),
               $urandom_range(0, 1) ? cnt + 32'($urandom_range(0, 4)) : 32'($urandom));
          send(ttco_pkg::REQ_WRITE, 10'($urandom), addr_of(t, ttco_pkg::OFF_MODE),
               mode_data());
          n_random += 3;
        end
      end
      for (k = 0; k < MIX_ITEMS; k++) begin
        t = $urandom_range(0, N_TIMERS - 1);
        sel = $urandom_range(0, 99);
        if (sel < 55) begin
          case ($urandom_range(0, 5))
            0:       c = '0;
            1:       c = 10'($urandom_range(0, 63) * 16);
            2:       c = 10'($urandom_range(0, 3) * 256);
            3:       c = 10'h3ff;
            default: c = 10'($urandom);
          endcase
          send(ttco_pkg::REQ_TICK, c, 16'($urandom), $urandom);
          n_random++;
        end else if (sel < 75) begin
          send(ttco_pkg::REQ_READ, 10'($urandom),
               addr_of(t, ttco_pkg::OFF_W'($urandom_range(0, 3))), $urandom);
          n_random++;
        end else if (sel < 92) begin
          send(ttco_pkg::REQ_WRITE, 10'($urandom),
               addr_of(t, ttco_pkg::OFF_W'($urandom_range(0, 3))), mode_data());
          n_random++;
        end else begin
          case ($urandom_range(0, 3))
            0: send(REQ_UNUSED, 10'($urandom), 16'($urandom), $urandom);
            1: send(reg_access(), 10'($urandom), 16'($urandom), $urandom);
            2: send(reg_access(), 10'($urandom),
                    addr_of($urandom_range(N_TIMERS, 31), ttco_pkg::OFF_W'($urandom)),
                    $urandom);
            default: send(reg_access(), 10'($urandom),
                          addr_of(t, ttco_pkg::OFF_W'($urandom_range(4, 15))), $urandom);
          endcase
          n_random++;
        end
      end
    end

    wait_for_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d ticks with %0d timer steps and %0d interrupts,",
             n_ticks, n_steps, n_irqs);
    $display("plus %0d register reads, %0d register writes and %0d unused requests.",
             n_reads, n_writes, n_unused);
    if (n_fail == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
